// ===== sv/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// shared types and constants of the polyphase rational resampler
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int MAX_RATE     = 256;
  localparam int MAX_TAPS     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 18;
  localparam int COEF_DEPTH   = MAX_RATE * MAX_TAPS;
  localparam int ADDR_BITS    = $clog2(COEF_DEPTH);
  localparam int RATE_BITS    = 9;
  localparam int TAPS_BITS    = 5;
  localparam int PHASE_BITS   = $clog2(MAX_RATE);
  localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS     = PROD_BITS + TAP_IDX_BITS + 2;
  localparam int FRAC_BITS    = COEF_BITS - 2;
  localparam int RESULT_LIMIT = 64;
  localparam int COUNT_BITS   = $clog2(RESULT_LIMIT) + 1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_UP_RATE   = 2'd0;
  localparam logic [1:0] REG_DOWN_RATE = 2'd1;
  localparam logic [1:0] REG_TAPS      = 2'd2;

  typedef enum logic {
    KIND_SAMPLE,
    KIND_COEF
  } item_kind_t;

  typedef struct packed {
    item_kind_t                    kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [ADDR_BITS-1:0]          coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
  } item_t;

  // clamped rates and a pulse that restarts the phase
  typedef struct packed {
    logic [RATE_BITS-1:0] up;
    logic [RATE_BITS-1:0] down;
    logic [TAPS_BITS-1:0] taps;
    logic                 clear;
  } rate_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDENT,
    ST_MAC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

// ===== sv/prr_front.sv =====
// ----------------------------------------------------------------------------
// prr_front
// accepts input requests, tags them by kind and queues them for the back end
// ----------------------------------------------------------------------------
module prr_front import prr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [ADDR_BITS-1:0]          coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  output logic                          q_valid,
  output item_t                         q_item,
  input  logic                          q_pop
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       incoming;
  logic        push;

  always_comb begin
    incoming.kind       = mode ? KIND_COEF : KIND_SAMPLE;
    incoming.sample     = sample;
    incoming.coef_index = coef_index;
    incoming.coef_value = coef_value;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== sv/prr_div.sv =====
// ----------------------------------------------------------------------------
// prr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module prr_div import prr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RATE_BITS-1:0] dividend,
  input  logic [RATE_BITS-1:0] divisor,
  output logic                 done,
  output logic [RATE_BITS-1:0] quo,
  output logic [RATE_BITS-1:0] rem
);

  localparam int CNT_BITS = $clog2(RATE_BITS + 1);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [RATE_BITS:0]   rem_r;
  logic [RATE_BITS-1:0] quo_r;
  logic [RATE_BITS-1:0] dvs;
  logic [RATE_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem_r[RATE_BITS-1:0], quo_r[RATE_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign quo   = quo_r;
  assign rem   = rem_r[RATE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem_r <= fits ? (trial - {1'b0, dvs}) : trial;
      quo_r <= {quo_r[RATE_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(RATE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/prr_back.sv =====
// ----------------------------------------------------------------------------
// prr_back
// history, coefficient memory, shared mac and phase sequencer
// ----------------------------------------------------------------------------
module prr_back import prr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  rate_cfg_t                     cfg,
  input  logic                          q_valid,
  input  item_t                         q_item,
  output logic                          q_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [SAMPLE_BITS-1:0] res_sample,
  output logic                          res_last
);

  back_state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
  logic signed [COEF_BITS-1:0]   rdata;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic [PHASE_BITS-1:0]         phase;
  logic [RATE_BITS-1:0]          skip;
  logic [COUNT_BITS-1:0]         n_out;
  logic [TAPS_BITS-1:0]          tap_issue;
  logic [ADDR_BITS-1:0]          addr;
  logic [TAP_IDX_BITS-1:0]       rd_tap;
  logic                          v1;
  logic                          v2;

  logic                 div_start;
  logic                 div_done;
  logic [RATE_BITS-1:0] div_quo;
  logic [RATE_BITS-1:0] div_rem;

  logic                          take_coef;
  logic                          take_sample;
  logic                          identity;
  logic                          emit_ok;
  logic                          step_go;
  logic                          issue;
  logic [TAPS_BITS-1:0]          hist_sel;
  logic [ADDR_BITS-1:0]          base_now;
  logic [ADDR_BITS-1:0]          base_next;
  logic signed [ACC_BITS-1:0]    rnd;
  logic signed [ACC_BITS-FRAC_BITS-1:0] shifted;
  logic signed [SAMPLE_BITS-1:0] sat;

  localparam logic signed [ACC_BITS-FRAC_BITS-1:0] SAT_HI =
    (ACC_BITS-FRAC_BITS)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-FRAC_BITS-1:0] SAT_LO =
    (ACC_BITS-FRAC_BITS)'(-(1 << (SAMPLE_BITS - 1)));

  prr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({1'b0, phase} + cfg.down),
    .divisor  (cfg.up),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign identity  = (cfg.up == cfg.down);
  assign emit_ok   = (n_out < COUNT_BITS'(RESULT_LIMIT));
  assign issue     = (state == ST_MAC) && emit_ok && (tap_issue < cfg.taps);
  assign hist_sel  = cfg.taps - TAPS_BITS'(1) - {1'b0, rd_tap};
  assign base_now  = ADDR_BITS'(phase * cfg.taps);
  assign base_next = ADDR_BITS'(div_rem[PHASE_BITS-1:0] * cfg.taps);

  // round half up, then saturate
  assign rnd     = acc + ACC_BITS'(1 << (FRAC_BITS - 1));
  assign shifted = rnd[ACC_BITS-1:FRAC_BITS];
  always_comb begin
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = shifted[SAMPLE_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_item.kind == KIND_SAMPLE) begin
          if (identity) begin
            state_next = ST_IDENT;
          end else if (skip == '0) begin
            state_next = ST_MAC;
          end
        end
      end
      ST_IDENT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (!issue && !v1 && !v2) begin
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step_go) begin
          state_next = (div_quo != '0) ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    res_sample = sat;
    res_last   = 1'b0;
    div_start  = 1'b0;
    step_go    = 1'b0;
    unique case (state)
      ST_IDLE:  q_pop = q_valid;
      ST_IDENT: begin
        res_valid  = 1'b1;
        res_sample = history[0];
        res_last   = 1'b1;
      end
      ST_DIV_START: div_start = 1'b1;
      ST_EMIT: begin
        res_valid = emit_ok;
        res_last  = (div_quo != '0) || (n_out == COUNT_BITS'(RESULT_LIMIT - 1));
        step_go   = !emit_ok || res_ready;
      end
      default: ;
    endcase
  end

  assign take_coef   = q_pop && q_item.kind == KIND_COEF;
  assign take_sample = q_pop && q_item.kind == KIND_SAMPLE;

  always_ff @(posedge clk) begin
    if (take_coef) begin
      coef_mem[q_item.coef_index] <= q_item.coef_value;
    end
    rdata <= coef_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        history[i] <= '0;
      end
    end else if (take_sample) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        history[i] <= history[i-1];
      end
      history[0] <= q_item.sample;
    end
  end

  // mac pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= history[hist_sel[TAP_IDX_BITS-1:0]] * rdata;
    end
    if (take_sample || step_go) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_BITS'(prod);
    end
    if (take_sample) begin
      addr <= base_now;
    end else if (step_go) begin
      addr <= base_next;
    end else if (issue) begin
      addr <= addr + 1'b1;
    end
    if (issue) begin
      rd_tap <= tap_issue[TAP_IDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      skip      <= '0;
      n_out     <= '0;
      tap_issue <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (issue) begin
        tap_issue <= tap_issue + 1'b1;
      end
      if (take_sample) begin
        n_out     <= '0;
        tap_issue <= '0;
        if (!identity && skip != '0) begin
          skip <= skip - 1'b1;
        end
      end
      if (step_go) begin
        phase     <= div_rem[PHASE_BITS-1:0];
        tap_issue <= '0;
        if (emit_ok) begin
          n_out <= n_out + 1'b1;
        end
        if (div_quo != '0) begin
          skip <= div_quo - 1'b1;
        end
      end
      if (cfg.clear) begin
        phase <= '0;
        skip  <= '0;
      end
    end
  end

endmodule

// ===== sv/polyphase_rational_resampler.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// rational L/M polyphase fir resampler for one audio channel
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_ready  | mode, sample, coef_index, coef_value
//  output   | out_valid/out_ready| out_sample, last_of_run
//  config   | apb psel/penable   | up_rate @0x0, down_rate @0x4, taps_per_phase @0x8
//
//  a coefficient request or a skipped sample is taken in the idle state of the back end
//  each output runs its taps through the shared mac, then the phase divider, then
//  is handed over to the output register; a two-entry queue
//  ahead of the back end and the output register let input and output stall
//  independently
//  rst is synchronous; history clears at once, coefficients must be loaded
// ----------------------------------------------------------------------------
module polyphase_rational_resampler import prr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // input requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [ADDR_BITS-1:0]          coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          last_of_run,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [RATE_BITS-1:0] up_rate;
  logic [RATE_BITS-1:0] down_rate;
  logic [TAPS_BITS-1:0] taps_per_phase;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  rate_cfg_t            cfg;

  logic                          q_valid;
  item_t                         q_item;
  logic                          q_pop;
  logic                          res_valid;
  logic                          res_ready;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_last;

  // register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rate        <= RATE_BITS'(1);
      down_rate      <= RATE_BITS'(1);
      taps_per_phase <= TAPS_BITS'(14);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_UP_RATE:   up_rate        <= pwdata[RATE_BITS-1:0];
        REG_DOWN_RATE: down_rate      <= pwdata[RATE_BITS-1:0];
        REG_TAPS:      taps_per_phase <= pwdata[TAPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_UP_RATE:   prdata = 32'(up_rate);
      REG_DOWN_RATE: prdata = 32'(down_rate);
      REG_TAPS:      prdata = 32'(taps_per_phase);
      default:       prdata = '0;
    endcase
  end

  // zero acts as one, oversized values pin to the maximum
  always_comb begin
    cfg.up = (up_rate == '0) ? RATE_BITS'(1) :
             (up_rate > RATE_BITS'(MAX_RATE)) ? RATE_BITS'(MAX_RATE) : up_rate;
    cfg.down = (down_rate == '0) ? RATE_BITS'(1) :
               (down_rate > RATE_BITS'(MAX_RATE)) ? RATE_BITS'(MAX_RATE) : down_rate;
    cfg.taps = (taps_per_phase == '0) ? TAPS_BITS'(1) :
               (taps_per_phase > TAPS_BITS'(MAX_TAPS)) ? TAPS_BITS'(MAX_TAPS) :
               taps_per_phase;
    // a rate change restarts the phase and the skip count
    cfg.clear = cfg_wr && (cfg_idx == REG_UP_RATE || cfg_idx == REG_DOWN_RATE);
  end

  prr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  prr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_sample (res_sample),
    .res_last   (res_last)
  );

  // output register, free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_sample  <= res_sample;
      last_of_run <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // the back end only takes requests the queue really holds
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // a result handed over always shows up on the output
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid) else $error("result lost");

  // a full output register with a stalled sink blocks the back end
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !res_ready) else $error("output overwritten");

endmodule

// ===== tb/polyphase_rational_resampler_test.sv =====
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_test
// self-checking bench: coefficient loads, sample requests at several L/M
// settings, predicted outputs compared in order under random idling and stalls
// ----------------------------------------------------------------------------
module polyphase_rational_resampler_test import prr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // settle time after the last output before a rate write, in cycles; the
  // back end may still step through dropped outputs after the last visible one
  localparam int SETTLE_CYCLES = 1024;
  localparam int CYCLE_LIMIT   = 3000000;
  // one random table covers every later setting with up * taps up to this
  localparam int COEF_LOAD     = 100;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] pcm;
    logic                          last;
  } pcm_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic [ADDR_BITS-1:0] coef_index = '0;
  logic signed [COEF_BITS-1:0] coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic last_of_run;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  polyphase_rational_resampler uut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [RATE_BITS-1:0] up_reg, down_reg;
  logic [TAPS_BITS-1:0] taps_reg;
  logic signed [SAMPLE_BITS-1:0] pcm_hist [MAX_TAPS];
  logic signed [COEF_BITS-1:0] coef_mem [COEF_DEPTH];
  int unsigned phase, skip;

  pcm_out_t pending_pcm[$];
  int errors = 0;
  int outputs_seen = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] phase_dot(int unsigned ph,
                                                             int unsigned t);
    longint acc;
    longint r;
    int unsigned a;
    acc = 0;
    for (int k = 0; k < t; k++) begin
      a = ph * t + k;
      if (a < COEF_DEPTH)
        acc += longint'(pcm_hist[t-1-k]) * longint'(coef_mem[a]);
    end
    // round half up, then saturate
    r = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic predict_request(logic m, logic signed [SAMPLE_BITS-1:0] s,
                                 logic [ADDR_BITS-1:0] idx,
                                 logic signed [COEF_BITS-1:0] cv);
    int unsigned up, dn, t, sum, adv, n;
    pcm_out_t o;
    up = clamp_val(up_reg, MAX_RATE);
    dn = clamp_val(down_reg, MAX_RATE);
    t = clamp_val(taps_reg, MAX_TAPS);
    n = 0;
    if (m) begin
      coef_mem[idx] = cv;
      return;
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) pcm_hist[k] = pcm_hist[k-1];
    pcm_hist[0] = s;
    if (up == dn) begin
      o.pcm = s;
      o.last = 1'b1;
      pending_pcm.push_back(o);
      return;
    end
    if (skip != 0) begin
      skip--;
      return;
    end
    if (phase >= up) phase = phase % up;
    forever begin
      if (n < RESULT_LIMIT) begin
        o.pcm = phase_dot(phase, t);
        o.last = 1'b0;
        pending_pcm.push_back(o);
        n++;
      end
      sum = phase + dn;
      adv = sum / up;
      phase = sum % up;
      if (adv != 0) begin
        skip = adv - 1;
        break;
      end
    end
    pending_pcm[pending_pcm.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic reg_write(logic [1:0] which, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {which, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (which)
      REG_UP_RATE: begin
        up_reg = val[RATE_BITS-1:0]; phase = 0; skip = 0;
      end
      REG_DOWN_RATE: begin
        down_reg = val[RATE_BITS-1:0]; phase = 0; skip = 0;
      end
      default: taps_reg = val[TAPS_BITS-1:0];
    endcase
  endtask

  // one request on the input channel; valid holds until accepted and drops
  // only when the sender idles or the stream ends
  task automatic send_request(logic m, logic signed [SAMPLE_BITS-1:0] s,
                              logic [ADDR_BITS-1:0] idx,
                              logic signed [COEF_BITS-1:0] cv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; sample <= s; coef_index <= idx; coef_value <= cv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(m, s, idx, cv);
    requests_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rates(int unsigned up, int unsigned dn, int unsigned t);
    drain_and_settle();
    reg_write(REG_UP_RATE, up);
    reg_write(REG_DOWN_RATE, dn);
    reg_write(REG_TAPS, t);
  endtask

  task automatic load_coefs(int unsigned count, bit extremes);
    logic signed [COEF_BITS-1:0] cv;
    for (int a = 0; a < count; a++) begin
      cv = COEF_BITS'($urandom);
      if (extremes) cv = (a % 2) ? 18'sh1ffff : 18'sh20000;
      send_request(1'b1, SAMPLE_BITS'($urandom), ADDR_BITS'(a), cv);
    end
  endtask

  // random samples, loud or small
  task automatic random_samples(int count);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int k = 0; k < count; k++) begin
      s = SAMPLE_BITS'($urandom);
      if ($urandom_range(3) == 0) s = $signed(s) >>> 6;
      send_request(1'b0, s, ADDR_BITS'($urandom), COEF_BITS'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(99) < recv_stall_pct) out_ready <= 1'b0;
      else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pcm_out_t want;
    if (!rst && out_valid && out_ready) begin
      outputs_seen++;
      if (pending_pcm.size() == 0) begin
        errors++;
        $display("%0t: unexpected output, expected none, actual %0d last %0b",
                 $time, out_sample, last_of_run);
      end else begin
        want = pending_pcm.pop_front();
        if (out_sample !== want.pcm) begin
          errors++;
          $display("%0t: out_sample expected %0d actual %0d", $time, want.pcm,
                   out_sample);
        end
        if (last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last,
                   last_of_run);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // identity rate at reset values passes samples through, field extremes
  task automatic test_identity();
    send_request(1'b0, 16'sh7fff, '0, '0);
    send_request(1'b0, 16'sh8000, 12'hfff, 18'sh1ffff);
    send_request(1'b0, 16'sh0000, '0, 18'sh20000);
    send_request(1'b0, 16'shffff, '0, '0);
    random_samples(10);
  endtask

  // interpolate by 3, extreme coefficients saturate both ways
  task automatic test_saturation();
    set_rates(3, 1, 8);
    load_coefs(24, 1'b1);
    send_request(1'b0, 16'sh7fff, '0, '0);
    send_request(1'b0, 16'sh8000, '0, '0);
    send_request(1'b0, 16'sh7fff, '0, '0);
    // top address of the coefficient memory
    send_request(1'b1, '0, 12'hfff, 18'sh0abcd);
  endtask

  // many ratios including skips, a single phase and wide tables
  task automatic test_ratios();
    int unsigned up, dn;
    load_coefs(COEF_LOAD, 1'b0);
    set_rates(2, 3, 4);   random_samples(30);
    set_rates(1, 4, 1);   random_samples(20);
    set_rates(5, 7, 3);   random_samples(30);
    send_idle_pct = 72;
    set_rates(7, 2, 12);  random_samples(25);
    send_idle_pct = 0; recv_stall_pct = 72;
    set_rates(4, 3, 8);   random_samples(30);
    send_idle_pct = 26; recv_stall_pct = 26;
    for (int k = 0; k < 4; k++) begin
      up = $urandom_range(1, 9);
      dn = $urandom_range(1, 9);
      set_rates(up, dn, 6); random_samples(15);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  // L = 100 caps at 64 outputs; out of range values clamp; rate 0 acts as 1
  task automatic test_limits();
    set_rates(100, 1, 1);  random_samples(3);
    // sender waits for every output before continuing
    drain_and_settle();
    random_samples(2);
    set_rates(1, 256, 2);  random_samples(12);
    set_rates(0, 511, 31); random_samples(8);
    set_rates(3, 0, 0);    random_samples(8);
    set_rates(5, 5, 4);    random_samples(6);
  endtask

  initial begin
    up_reg = 1; down_reg = 1; taps_reg = 14; phase = 0; skip = 0;
    foreach (pcm_hist[k]) pcm_hist[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_identity();
    test_saturation();
    test_ratios();
    test_limits();
    drain_and_settle();
    $display("sent %0d requests over identity, up, down, clamped and capped rates",
             requests_sent);
    $display("checked %0d outputs with random source idling and sink stalls",
             outputs_seen);
    if (errors == 0 && pending_pcm.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
